@@ rtl/nsem_pkg.sv @@
// ----------------------------------------------------------------------------
// nsem_pkg
// Shared types, constants and the microcode program of the smooth size search.
// ----------------------------------------------------------------------------
package nsem_pkg;

  localparam int unsigned BaseW  = 17;  // configured base
  localparam int unsigned SizeW  = 35;  // result field
  localparam int unsigned GoalW  = 36;  // even-rounded target, below the limit
  localparam int unsigned PW     = 37;  // row value base2 * 3^j
  localparam int unsigned QW     = 38;  // column value p * 5^k
  localparam int unsigned RW     = 39;  // aligned candidate q * 2^i
  localparam int unsigned ShW    = 6;   // count of doublings
  localparam int unsigned StepW  = 4;

  localparam logic [SizeW-1:0] SizeLimit = '1;

  // Reciprocals for exact division of BaseW-bit values by 3 and by 5.
  localparam int unsigned       RecipShift = 24;
  localparam int unsigned       RecipW     = 23;
  localparam logic [RecipW-1:0] Recip3     = 23'd5592406;
  localparam logic [RecipW-1:0] Recip5     = 23'd3355444;

  typedef logic [StepW-1:0] step_t;

  localparam step_t S_WAIT   = 4'd0;
  localparam step_t S_SMALL  = 4'd1;
  localparam step_t S_BIG    = 4'd2;
  localparam step_t S_STRIP2 = 4'd3;
  localparam step_t S_STRIP3 = 4'd4;
  localparam step_t S_STRIP5 = 4'd5;
  localparam step_t S_BASE   = 4'd6;
  localparam step_t S_ALIGN  = 4'd7;
  localparam step_t S_OUTER  = 4'd8;
  localparam step_t S_INNER  = 4'd9;
  localparam step_t S_EMIT   = 4'd10;
  localparam step_t S_LAST   = S_EMIT;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SET_TWO,
    OP_SET_NF,
    OP_LOAD_BASE,
    OP_STRIP2,
    OP_STRIP3,
    OP_STRIP5,
    OP_INIT_P,
    OP_ALIGN,
    OP_START_Q,
    OP_STEP_Q,
    OP_STEP_P,
    OP_FINISH,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    C_IN_VALID,
    C_SMALL,
    C_BIG,
    C_EVEN,
    C_DIV3,
    C_DIV5,
    C_BASE_BAD,
    C_ALIGN_LOW,
    C_P_OVER,
    C_Q_OVER,
    C_OUT_FREE
  } cond_e;

  typedef struct packed {
    logic in_valid;
    logic low_tgt;
    logic big;
    logic even;
    logic div3;
    logic div5;
    logic base_bad;
    logic align_low;
    logic p_over;
    logic q_over;
    logic out_free;
  } status_t;

  typedef struct packed {
    op_e  op;
    logic idle;
  } ctrl_t;

  typedef struct packed {
    cond_e cond;
    op_e   op_hit;
    step_t jmp_hit;
    op_e   op_miss;
    step_t jmp_miss;
  } uword_t;

  // Control store: one word per step, a condition selects op and next step.
  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      S_WAIT:   w = '{C_IN_VALID,  OP_LOAD,    S_SMALL,  OP_NONE,      S_WAIT};
      S_SMALL:  w = '{C_SMALL,     OP_SET_TWO, S_EMIT,   OP_NONE,      S_BIG};
      S_BIG:    w = '{C_BIG,       OP_SET_NF,  S_EMIT,   OP_LOAD_BASE, S_STRIP2};
      S_STRIP2: w = '{C_EVEN,      OP_STRIP2,  S_STRIP2, OP_NONE,      S_STRIP3};
      S_STRIP3: w = '{C_DIV3,      OP_STRIP3,  S_STRIP3, OP_NONE,      S_STRIP5};
      S_STRIP5: w = '{C_DIV5,      OP_STRIP5,  S_STRIP5, OP_NONE,      S_BASE};
      S_BASE:   w = '{C_BASE_BAD,  OP_SET_NF,  S_EMIT,   OP_INIT_P,    S_ALIGN};
      S_ALIGN:  w = '{C_ALIGN_LOW, OP_ALIGN,   S_ALIGN,  OP_NONE,      S_OUTER};
      S_OUTER:  w = '{C_P_OVER,    OP_FINISH,  S_EMIT,   OP_START_Q,   S_INNER};
      S_INNER:  w = '{C_Q_OVER,    OP_STEP_P,  S_OUTER,  OP_STEP_Q,    S_INNER};
      S_EMIT:   w = '{C_OUT_FREE,  OP_EMIT,    S_WAIT,   OP_NONE,      S_EMIT};
      default:  w = '{C_IN_VALID,  OP_NONE,    S_WAIT,   OP_NONE,      S_WAIT};
    endcase
    return w;
  endfunction

  // Quotient of n by a small constant through its scaled reciprocal.
  function automatic logic [BaseW-1:0] div_const(logic [BaseW-1:0] n,
                                                 logic [RecipW-1:0] m);
    logic [BaseW+RecipW-1:0] prod;
    prod = {{RecipW{1'b0}}, n} * {{BaseW{1'b0}}, m};
    return {1'b0, prod[RecipShift +: BaseW-1]};
  endfunction

endpackage

@@ rtl/nsem_in_if.sv @@
// ----------------------------------------------------------------------------
// nsem_in_if
// Request channel: one target length per transaction.
// ----------------------------------------------------------------------------
interface nsem_in_if #(
  parameter int unsigned TARGET_WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic [TARGET_WIDTH-1:0] target;

  modport source (output valid, output target, input ready);
  modport sink   (input valid, input target, output ready);
endinterface

@@ rtl/nsem_out_if.sv @@
// ----------------------------------------------------------------------------
// nsem_out_if
// Result channel: smooth size and not-found flag per transaction.
// ----------------------------------------------------------------------------
interface nsem_out_if;
  logic        valid;
  logic        ready;
  logic [34:0] smooth_size;
  logic        not_found;

  modport source (output valid, output smooth_size, output not_found, input ready);
  modport sink   (input valid, input smooth_size, input not_found, output ready);
endinterface

@@ rtl/nsem_seq.sv @@
// ----------------------------------------------------------------------------
// nsem_seq
// Step counter and control store that drive the search datapath.
// ----------------------------------------------------------------------------
module nsem_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nsem_pkg::status_t status_i,
  output nsem_pkg::ctrl_t   ctrl_o
);
  import nsem_pkg::*;

  step_t  step_q, step_d;
  uword_t word;
  logic   hit;

  assign word = ucode(step_q);

  always_comb begin
    case (word.cond)
      C_IN_VALID:  hit = status_i.in_valid;
      C_SMALL:     hit = status_i.low_tgt;
      C_BIG:       hit = status_i.big;
      C_EVEN:      hit = status_i.even;
      C_DIV3:      hit = status_i.div3;
      C_DIV5:      hit = status_i.div5;
      C_BASE_BAD:  hit = status_i.base_bad;
      C_ALIGN_LOW: hit = status_i.align_low;
      C_P_OVER:    hit = status_i.p_over;
      C_Q_OVER:    hit = status_i.q_over;
      C_OUT_FREE:  hit = status_i.out_free;
      default:     hit = 1'b0;
    endcase
  end

  assign step_d      = hit ? word.jmp_hit : word.jmp_miss;
  assign ctrl_o.op   = hit ? word.op_hit : word.op_miss;
  assign ctrl_o.idle = (step_q == S_WAIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) step_q <= S_LAST)
    else $error("step counter left the program");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_i.in_valid && ctrl_o.idle) |=> (step_q == S_SMALL))
    else $error("accepted transaction did not start the program");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_EMIT && status_i.out_free) |=> (step_q == S_WAIT))
    else $error("result handoff did not return to wait");

endmodule

@@ rtl/nsem_dp.sv @@
// ----------------------------------------------------------------------------
// nsem_dp
// Datapath of the search: base stripping, row and column stepping, result.
// ----------------------------------------------------------------------------
module nsem_dp #(
  parameter int unsigned TARGET_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nsem_pkg::ctrl_t               ctrl_i,
  output nsem_pkg::status_t             status_o,
  input  logic                          in_valid_i,
  input  logic [TARGET_WIDTH-1:0]       target_i,
  input  logic [nsem_pkg::BaseW-1:0]    base_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [nsem_pkg::SizeW-1:0]    smooth_size_o,
  output logic                          not_found_o
);
  import nsem_pkg::*;

  localparam int unsigned WideW = (TARGET_WIDTH > GoalW) ? TARGET_WIDTH : GoalW;

  logic [WideW-1:0] tgt_ext, tgt_even;
  logic             small_q, big_q;
  logic [GoalW-1:0] goal_q;
  logic [RW-1:0]    goal_r;

  logic [BaseW-1:0] b_q, quo3, quo5;
  logic [BaseW:0]   m3;
  logic [BaseW+1:0] m5;
  logic [BaseW:0]   base2;

  logic [PW-1:0]  p_q, p3;
  logic [RW-1:0]  pr_q, r3, pr_next;
  logic [ShW-1:0] pi_q, pi_next;
  logic [QW-1:0]  q_q, q5;
  logic [RW-1:0]  qr_q, r5, qr_next;
  logic [ShW-1:0] qi_q, qi_next;

  logic [SizeW-1:0] best_q;
  logic             have_q, cand_ok;
  logic [SizeW-1:0] res_size_q, out_size_q;
  logic             res_nf_q, out_nf_q, out_valid_q;

  // Request decode; the goal is the target rounded up to even.
  assign tgt_ext  = WideW'(target_i);
  assign tgt_even = tgt_ext + WideW'(tgt_ext[0]);
  assign goal_r   = RW'(goal_q);

  assign quo3  = div_const(b_q, Recip3);
  assign quo5  = div_const(b_q, Recip5);
  assign m3    = {quo3, 1'b0} + {1'b0, quo3};
  assign m5    = {quo5, 2'b00} + {2'b00, quo5};
  assign base2 = base_i[0] ? {base_i, 1'b0} : {1'b0, base_i};

  // Stepping a row or column scales the aligned candidate, then gives back
  // doublings that are no longer needed to stay at or above the goal.
  assign p3 = (p_q << 1) + p_q;
  assign r3 = (pr_q << 1) + pr_q;
  assign q5 = (q_q << 2) + q_q;
  assign r5 = (qr_q << 2) + qr_q;

  always_comb begin
    qr_next = r5;
    qi_next = qi_q;
    if (qi_q >= ShW'(3) && (r5 >> 3) >= goal_r) begin
      qr_next = r5 >> 3;
      qi_next = qi_q - ShW'(3);
    end else if (qi_q >= ShW'(2) && (r5 >> 2) >= goal_r) begin
      qr_next = r5 >> 2;
      qi_next = qi_q - ShW'(2);
    end else if (qi_q >= ShW'(1) && (r5 >> 1) >= goal_r) begin
      qr_next = r5 >> 1;
      qi_next = qi_q - ShW'(1);
    end
  end

  always_comb begin
    pr_next = r3;
    pi_next = pi_q;
    if (pi_q >= ShW'(2) && (r3 >> 2) >= goal_r) begin
      pr_next = r3 >> 2;
      pi_next = pi_q - ShW'(2);
    end else if (pi_q >= ShW'(1) && (r3 >> 1) >= goal_r) begin
      pr_next = r3 >> 1;
      pi_next = pi_q - ShW'(1);
    end
  end

  assign cand_ok = (qr_q <= RW'(SizeLimit)) &&
                   (!have_q || (qr_q[SizeW-1:0] < best_q));

  assign status_o.in_valid  = in_valid_i;
  assign status_o.low_tgt   = small_q;
  assign status_o.big       = big_q;
  assign status_o.even      = (b_q != '0) && !b_q[0];
  assign status_o.div3      = (b_q != '0) && (m3 == {1'b0, b_q});
  assign status_o.div5      = (b_q != '0) && (m5 == {2'b00, b_q});
  assign status_o.base_bad  = (base_i == '0) || (b_q != BaseW'(1));
  assign status_o.align_low = pr_q < goal_r;
  assign status_o.p_over    = p_q > PW'(SizeLimit);
  assign status_o.q_over    = q_q > QW'(SizeLimit);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_LOAD: begin
        small_q <= tgt_ext <= WideW'(2);
        big_q   <= tgt_ext >= WideW'(SizeLimit);
        goal_q  <= tgt_even[GoalW-1:0];
      end
      OP_SET_TWO: begin
        res_size_q <= SizeW'(2);
        res_nf_q   <= 1'b0;
      end
      OP_SET_NF: begin
        res_size_q <= '0;
        res_nf_q   <= 1'b1;
      end
      OP_LOAD_BASE: b_q <= base_i;
      OP_STRIP2:    b_q <= b_q >> 1;
      OP_STRIP3:    b_q <= quo3;
      OP_STRIP5:    b_q <= quo5;
      OP_INIT_P: begin
        p_q  <= PW'(base2);
        pr_q <= RW'(base2);
        pi_q <= '0;
      end
      OP_ALIGN: begin
        pr_q <= pr_q << 1;
        pi_q <= pi_q + ShW'(1);
      end
      OP_START_Q: begin
        q_q  <= QW'(p_q);
        qr_q <= pr_q;
        qi_q <= pi_q;
      end
      OP_STEP_Q: begin
        q_q  <= q5;
        qr_q <= qr_next;
        qi_q <= qi_next;
        if (cand_ok) begin
          best_q <= qr_q[SizeW-1:0];
        end
      end
      OP_STEP_P: begin
        p_q  <= p3;
        pr_q <= pr_next;
        pi_q <= pi_next;
      end
      OP_FINISH: begin
        res_size_q <= have_q ? best_q : '0;
        res_nf_q   <= !have_q;
      end
      OP_EMIT: begin
        out_size_q <= res_size_q;
        out_nf_q   <= res_nf_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.op == OP_INIT_P) begin
        have_q <= 1'b0;
      end else if (ctrl_i.op == OP_STEP_Q && cand_ok) begin
        have_q <= 1'b1;
      end
      if (ctrl_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign smooth_size_o = out_size_q;
  assign not_found_o   = out_nf_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl_i.op == OP_EMIT))
    else $error("result presented without an emit step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_nf_q) |-> (out_size_q != '0 && !out_size_q[0]))
    else $error("found size is not a positive even value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_STEP_Q && qi_q != '0) |-> (qr_q < {goal_r[RW-2:0], 1'b0}))
    else $error("aligned candidate carries a surplus doubling");

endmodule

@@ rtl/next_smooth_even_multiple_top.sv @@
// ----------------------------------------------------------------------------
// next_smooth_even_multiple_top
// Smallest even 2-3-5-smooth multiple of a configured base at or above a target.
// ----------------------------------------------------------------------------
// Targets of 2 or less give 2 and targets beyond the result range give not
// found; otherwise the base is stripped of its 2, 3 and 5 factors, the first
// row is doubled up to the goal (at most 35 doublings) and the search grid is
// walked row by row and column by column. A base of 0 or with other factors
// gives not found. One transaction at a time.
// Reset: base register to 1, sequencer to wait, no result pending.
module next_smooth_even_multiple_top #(
  parameter int unsigned TARGET_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  nsem_in_if.sink     in_i,
  nsem_out_if.source  out_o
);
  import nsem_pkg::*;

  logic [BaseW-1:0] multiple_of_q;
  status_t          status;
  ctrl_t            ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      multiple_of_q <= BaseW'(1);
    end else if (cfg_we_i) begin
      multiple_of_q <= cfg_wdata_i;
    end
  end

  nsem_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  nsem_dp #(
    .TARGET_WIDTH (TARGET_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .in_valid_i    (in_i.valid),
    .target_i      (in_i.target),
    .base_i        (multiple_of_q),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .smooth_size_o (out_o.smooth_size),
    .not_found_o   (out_o.not_found)
  );

  assign in_i.ready = ctrl.idle;

endmodule
